/* hdl/rtc_pkg.sv */
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared widths, register indexes and types of the ray/triangle hit core.
// ----------------------------------------------------------------------------
package rtc_pkg;

    // default build values
    localparam int DEF_COORD_BITS    = 16;
    localparam int DEF_MAX_TRIANGLES = 65536;

    // datapath widths
    localparam int FIELD_W = 16;   // Q8.8 field
    localparam int VEC_W   = 17;   // edge / offset vector component
    localparam int CROSS_W = 35;   // cross product component, Q19.16
    localparam int ACC_W   = 56;   // dot product accumulator, Q32.24
    localparam int DEN_W   = 55;   // magnitude of det or t numerator
    localparam int DIST_W  = 32;   // Q16.16 distance
    localparam int FRAC_W  = 16;   // fraction bits of distance
    localparam int THR_W   = 32;
    localparam int CFG_AW  = 3;

    // register indexes
    localparam logic [CFG_AW-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_DIR_X    = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_DIR_Y    = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_DIR_Z    = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_THRESH   = 3'd6;

    // one multiply-accumulate request
    typedef struct packed {
        logic                      en;
        logic                      clr;
        logic                      sub;
        logic signed [CROSS_W-1:0] a;
        logic signed [VEC_W-1:0]   b;
    } t_mac_op;

    // divider status
    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] q;
    } t_div_res;

endpackage

/* hdl/rtc_mac.sv */
// ----------------------------------------------------------------------------
// rtc_mac
// Shared signed multiply-accumulate unit for cross and dot products.
// ----------------------------------------------------------------------------
module rtc_mac (
    input  logic                            i_clk,
    input  rtc_pkg::t_mac_op                i_op,
    output logic signed [rtc_pkg::ACC_W-1:0] o_sum
);
    import rtc_pkg::*;

    logic signed [CROSS_W+VEC_W-1:0] w_prod;
    logic signed [ACC_W-1:0]         w_prod_x;
    logic signed [ACC_W-1:0]         w_base;
    logic signed [ACC_W-1:0]         r_acc;
    logic signed [ACC_W-1:0]         n_acc;

    // product, then add or subtract into the running sum
    always_comb begin
        w_prod   = i_op.a * i_op.b;
        w_prod_x = {{(ACC_W-CROSS_W-VEC_W){w_prod[CROSS_W+VEC_W-1]}}, w_prod};
        w_base   = i_op.clr ? '0 : r_acc;
        n_acc    = i_op.sub ? (w_base - w_prod_x) : (w_base + w_prod_x);
    end

    assign o_sum = n_acc;

    always_ff @(posedge i_clk) begin
        if (i_op.en) begin
            r_acc <= n_acc;
        end
    end
endmodule

/* hdl/rtc_div.sv */
// ----------------------------------------------------------------------------
// rtc_div
// Serial restoring divider: Q16.16 quotient of num/den, saturating.
// ----------------------------------------------------------------------------
module rtc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rtc_pkg::DEN_W-1:0]   i_num,
    input  logic [rtc_pkg::DEN_W-1:0]   i_den,
    output rtc_pkg::t_div_res           o_res
);
    import rtc_pkg::*;

    localparam int CNT_W = $clog2(DIST_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [DIST_W-1:0] r_sh;
    logic [DIST_W-1:0] r_q;
    logic [DEN_W:0]    w_trial;
    logic              w_sat;

    always_comb begin
        w_trial = {r_rem, r_sh[DIST_W-1]};
        w_sat   = {{FRAC_W{1'b0}}, i_num} >= {i_den, {FRAC_W{1'b0}}};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= !w_sat;
                r_done <= w_sat;
                r_cnt  <= CNT_W'(DIST_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= {{FRAC_W{1'b0}}, i_num[DEN_W-1:FRAC_W]};
            r_sh  <= {i_num[FRAC_W-1:0], {(DIST_W-FRAC_W){1'b0}}};
            r_q   <= w_sat ? '1 : '0;
        end else if (r_busy) begin
            r_sh <= {r_sh[DIST_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_den}) begin
                r_rem <= DEN_W'(w_trial - {1'b0, r_den});
                r_q   <= {r_q[DIST_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[DEN_W-1:0];
                r_q   <= {r_q[DIST_W-2:0], 1'b0};
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.q    = r_q;
endmodule

/* hdl/ray_triangle_closest_hit_core.sv */
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit_core
// Moller-Trumbore ray/triangle test with a closest-hit record per mesh.
// ----------------------------------------------------------------------------
// Usage: write the ray (origin, direction, parallel threshold) on the cfg
// port while idle. Stream triangles on s_axis: tdata holds nine Q8.8
// coordinates, tlast marks the final triangle of a mesh. Each triangle gives
// one item on m_axis: tdata = distance, best distance and best index,
// tuser = hit and any-hit flags, tlast = copy of the input tlast.
// Sequence: one shared multiply-accumulate unit runs 24 steps for the cross
// and dot products, then the sign fix-up and bound tests, then (on a hit
// only) the serial divider for the distance, and then a final state that
// posts the result to the output register of m_axis.
// One triangle is in flight at a time; s_axis tready is high only while idle.
// The result sits in an output register, so the next triangle is accepted
// while it waits; a stalled receiver holds the core at the posting step.
// Reset (synchronous, active low) restores the default ray, clears the
// record and the triangle count, and empties the output register.
// ----------------------------------------------------------------------------
module ray_triangle_closest_hit_core #(
    parameter int COORD_BITS    = rtc_pkg::DEF_COORD_BITS,
    parameter int MAX_TRIANGLES = rtc_pkg::DEF_MAX_TRIANGLES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write port
    input  logic                          i_cfg_we,
    input  logic [rtc_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  logic [rtc_pkg::THR_W-1:0]     i_cfg_wdata,
    // triangles
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (16 bits each)
    input  logic [143:0]                  i_s_axis_tdata,
    input  logic                          i_s_axis_tlast,  // final_triangle
    // results
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // distance (32), best_distance (32), best_index (16)
    output logic [79:0]                   o_m_axis_tdata,
    // hit, any_hit
    output logic [1:0]                    o_m_axis_tuser,
    output logic                          o_m_axis_tlast   // is_last
);
    import rtc_pkg::*;

    localparam int EXT_BITS = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int EXT_SH   = FIELD_W - EXT_BITS;
    localparam int CNT_W    = $clog2(MAX_TRIANGLES);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAC   = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_TEST  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam logic [4:0] LAST_STEP = 5'd23;

    // sign-extend a field from the coordinate width
    function automatic logic signed [VEC_W-1:0] coord(input logic [FIELD_W-1:0] v);
        logic signed [FIELD_W-1:0] t;
        t = $signed(v << EXT_SH) >>> EXT_SH;
        return {t[FIELD_W-1], t};
    endfunction

    function automatic logic signed [CROSS_W-1:0] ext_a(input logic signed [VEC_W-1:0] v);
        return {{(CROSS_W-VEC_W){v[VEC_W-1]}}, v};
    endfunction

    // config registers
    logic [FIELD_W-1:0] r_org [3];
    logic [FIELD_W-1:0] r_dir [3];
    logic [THR_W-1:0]   r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_dir[0] <= '0;
            r_dir[1] <= '0;
            r_dir[2] <= 16'd256;
            r_thr    <= 32'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_ORIGIN_X: r_org[0] <= i_cfg_wdata[FIELD_W-1:0];
                CFG_ORIGIN_Y: r_org[1] <= i_cfg_wdata[FIELD_W-1:0];
                CFG_ORIGIN_Z: r_org[2] <= i_cfg_wdata[FIELD_W-1:0];
                CFG_DIR_X:    r_dir[0] <= i_cfg_wdata[FIELD_W-1:0];
                CFG_DIR_Y:    r_dir[1] <= i_cfg_wdata[FIELD_W-1:0];
                CFG_DIR_Z:    r_dir[2] <= i_cfg_wdata[FIELD_W-1:0];
                CFG_THRESH:   r_thr    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic signed [VEC_W-1:0] w_d [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d[i] = coord(r_dir[i]);
        end
    end

    // sequencer state
    logic [2:0] r_state;
    logic [4:0] r_step;
    logic       r_last;
    logic       w_accept;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // edge and offset vectors, loaded at accept
    logic signed [VEC_W-1:0]   r_e1 [3];
    logic signed [VEC_W-1:0]   r_e2 [3];
    logic signed [VEC_W-1:0]   r_s  [3];
    logic signed [CROSS_W-1:0] r_pv [3];
    logic signed [CROSS_W-1:0] r_qv [3];
    logic signed [ACC_W-1:0]   r_det, r_un, r_vn, r_tn;
    logic                      r_par_ok;
    logic                      r_hit;
    logic [DIST_W-1:0]         r_dist;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= coord(i_s_axis_tdata[(3+i)*FIELD_W +: FIELD_W])
                         - coord(i_s_axis_tdata[i*FIELD_W +: FIELD_W]);
                r_e2[i] <= coord(i_s_axis_tdata[(6+i)*FIELD_W +: FIELD_W])
                         - coord(i_s_axis_tdata[i*FIELD_W +: FIELD_W]);
                r_s[i]  <= coord(r_org[i])
                         - coord(i_s_axis_tdata[i*FIELD_W +: FIELD_W]);
            end
            r_last <= i_s_axis_tlast;
        end
    end

    // operand schedule for the shared MAC
    t_mac_op                 w_op;
    logic signed [ACC_W-1:0] w_sum;

    always_comb begin
        w_op.en  = (r_state == ST_MAC);
        w_op.clr = 1'b0;
        w_op.sub = 1'b0;
        w_op.a   = '0;
        w_op.b   = '0;
        unique case (r_step)
            // pv = d x e2
            5'd0:  begin w_op.clr = 1'b1; w_op.a = ext_a(r_e2[2]); w_op.b = w_d[1]; end
            5'd1:  begin w_op.sub = 1'b1; w_op.a = ext_a(r_e2[1]); w_op.b = w_d[2]; end
            5'd2:  begin w_op.clr = 1'b1; w_op.a = ext_a(r_e2[0]); w_op.b = w_d[2]; end
            5'd3:  begin w_op.sub = 1'b1; w_op.a = ext_a(r_e2[2]); w_op.b = w_d[0]; end
            5'd4:  begin w_op.clr = 1'b1; w_op.a = ext_a(r_e2[1]); w_op.b = w_d[0]; end
            5'd5:  begin w_op.sub = 1'b1; w_op.a = ext_a(r_e2[0]); w_op.b = w_d[1]; end
            // det = e1 . pv
            5'd6:  begin w_op.clr = 1'b1; w_op.a = r_pv[0]; w_op.b = r_e1[0]; end
            5'd7:  begin w_op.a = r_pv[1]; w_op.b = r_e1[1]; end
            5'd8:  begin w_op.a = r_pv[2]; w_op.b = r_e1[2]; end
            // qv = s x e1
            5'd9:  begin w_op.clr = 1'b1; w_op.a = ext_a(r_e1[2]); w_op.b = r_s[1]; end
            5'd10: begin w_op.sub = 1'b1; w_op.a = ext_a(r_e1[1]); w_op.b = r_s[2]; end
            5'd11: begin w_op.clr = 1'b1; w_op.a = ext_a(r_e1[0]); w_op.b = r_s[2]; end
            5'd12: begin w_op.sub = 1'b1; w_op.a = ext_a(r_e1[2]); w_op.b = r_s[0]; end
            5'd13: begin w_op.clr = 1'b1; w_op.a = ext_a(r_e1[1]); w_op.b = r_s[0]; end
            5'd14: begin w_op.sub = 1'b1; w_op.a = ext_a(r_e1[0]); w_op.b = r_s[1]; end
            // u numerator = s . pv
            5'd15: begin w_op.clr = 1'b1; w_op.a = r_pv[0]; w_op.b = r_s[0]; end
            5'd16: begin w_op.a = r_pv[1]; w_op.b = r_s[1]; end
            5'd17: begin w_op.a = r_pv[2]; w_op.b = r_s[2]; end
            // v numerator = d . qv
            5'd18: begin w_op.clr = 1'b1; w_op.a = r_qv[0]; w_op.b = w_d[0]; end
            5'd19: begin w_op.a = r_qv[1]; w_op.b = w_d[1]; end
            5'd20: begin w_op.a = r_qv[2]; w_op.b = w_d[2]; end
            // t numerator = e2 . qv
            5'd21: begin w_op.clr = 1'b1; w_op.a = r_qv[0]; w_op.b = r_e2[0]; end
            5'd22: begin w_op.a = r_qv[1]; w_op.b = r_e2[1]; end
            5'd23: begin w_op.a = r_qv[2]; w_op.b = r_e2[2]; end
            default: ;
        endcase
    end

    rtc_mac u_mac (
        .i_clk (i_clk),
        .i_op  (w_op),
        .o_sum (w_sum)
    );

    // capture finished sums
    always_ff @(posedge i_clk) begin
        if (r_state == ST_MAC) begin
            unique case (r_step)
                5'd1:    r_pv[0] <= w_sum[CROSS_W-1:0];
                5'd3:    r_pv[1] <= w_sum[CROSS_W-1:0];
                5'd5:    r_pv[2] <= w_sum[CROSS_W-1:0];
                5'd8:    r_det   <= w_sum;
                5'd10:   r_qv[0] <= w_sum[CROSS_W-1:0];
                5'd12:   r_qv[1] <= w_sum[CROSS_W-1:0];
                5'd14:   r_qv[2] <= w_sum[CROSS_W-1:0];
                5'd17:   r_un    <= w_sum;
                5'd20:   r_vn    <= w_sum;
                5'd23:   r_tn    <= w_sum;
                default: ;
            endcase
        end else if (r_state == ST_CHECK) begin
            // make det positive, flipping the numerators with it
            if (r_det < 0) begin
                r_det <= -r_det;
                r_un  <= -r_un;
                r_vn  <= -r_vn;
                r_tn  <= -r_tn;
            end
        end
    end

    // parallel test on the raw determinant
    logic [ACC_W-1:0] w_mag;
    logic             w_in_tri;

    assign w_mag = (r_det < 0) ? ACC_W'(-r_det) : ACC_W'(r_det);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CHECK) begin
            r_par_ok <= (r_det != 0) && (w_mag >= {{(ACC_W-THR_W){1'b0}}, r_thr});
        end
    end

    assign w_in_tri = r_par_ok && (r_un >= 0) && (r_un <= r_det) && (r_vn >= 0)
                   && ((r_un + r_vn) <= r_det) && (r_tn >= 0);

    // distance divider
    t_div_res w_div;
    logic     w_div_start;

    assign w_div_start = (r_state == ST_TEST) && w_in_tri;

    rtc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_tn[DEN_W-1:0]),
        .i_den   (r_det[DEN_W-1:0]),
        .o_res   (w_div)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == ST_TEST) begin
            r_hit  <= w_in_tri;
            r_dist <= '0;
        end else if ((r_state == ST_DIV) && w_div.done) begin
            r_dist <= w_div.q;
        end
    end

    // closest-hit record
    logic              r_have;
    logic [DIST_W-1:0] r_best;
    logic [CNT_W-1:0]  r_pos;
    logic [CNT_W-1:0]  r_count;
    logic              w_post;
    logic              w_take;
    logic              n_have;
    logic [DIST_W-1:0] n_best;
    logic [CNT_W-1:0]  n_pos;

    assign w_post = (r_state == ST_DONE) && (!o_m_axis_tvalid || i_m_axis_tready);
    assign w_take = r_hit && (!r_have || (r_dist < r_best));

    always_comb begin
        n_have = r_have || r_hit;
        n_best = w_take ? r_dist : r_best;
        n_pos  = w_take ? r_count : r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have  <= 1'b0;
            r_best  <= '0;
            r_pos   <= '0;
            r_count <= '0;
        end else if (w_post) begin
            if (r_last) begin
                r_have  <= 1'b0;
                r_best  <= '0;
                r_pos   <= '0;
                r_count <= '0;
            end else begin
                r_have  <= n_have;
                r_best  <= n_best;
                r_pos   <= n_pos;
                r_count <= (r_count == CNT_W'(MAX_TRIANGLES - 1)) ? '0 : r_count + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_axis_tvalid <= 1'b0;
        end else if (w_post) begin
            o_m_axis_tvalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            o_m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_post) begin
            o_m_axis_tdata[31:0]  <= r_dist;
            o_m_axis_tdata[63:32] <= n_best;
            o_m_axis_tdata[79:64] <= 16'(n_pos);
            o_m_axis_tuser        <= {n_have, r_hit};
            o_m_axis_tlast        <= r_last;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_step <= '0;
                    if (w_accept) begin
                        r_state <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == LAST_STEP) begin
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: r_state <= ST_TEST;
                ST_TEST:  r_state <= w_in_tri ? ST_DIV : ST_DONE;
                ST_DIV: begin
                    if (w_div.done) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_post) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // checks
    a_miss_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata[31:0] == '0))
        else $error("miss with nonzero distance");

    a_no_best_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[1]) |-> (o_m_axis_tdata[79:32] == '0))
        else $error("empty record with nonzero best fields");

    a_hit_in_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |->
        (o_m_axis_tuser[1] && (o_m_axis_tdata[63:32] <= o_m_axis_tdata[31:0])))
        else $error("hit not reflected in closest record");

    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == ST_DIV))
        else $error("divider finished outside divide step");
endmodule
